FILE: rtl/sei_pkg.sv
// ----------------------------------------------------------------------------
// sei_pkg
// Shared types, register offsets and operation codes of the interrupt
// aggregator.
// ----------------------------------------------------------------------------
`default_nettype none

package sei_pkg;

  // Default sizing
  localparam int SOURCE_COUNT_DEF = 64;
  localparam int WIRED_MAX_DEF    = 32;

  // Fixed widths of the bus and state words
  localparam int WORD_W   = 32;
  localparam int CAUSE_W  = 64;
  localparam int ADDR_W   = 6;
  localparam int INDEX_W  = 6;
  localparam int COUNT_W  = 6;

  // Reset value of the wired source count
  localparam logic [COUNT_W-1:0] WIRED_COUNT_RST = 6'd21;

  // Depth of the queue between the decoder and the state engine
  localparam int QUEUE_DEPTH = 2;

  // Register offsets
  localparam logic [ADDR_W-1:0] OFF_CAUSE_LO = 6'h00;
  localparam logic [ADDR_W-1:0] OFF_CAUSE_HI = 6'h04;
  localparam logic [ADDR_W-1:0] OFF_MASK_LO  = 6'h20;
  localparam logic [ADDR_W-1:0] OFF_MASK_HI  = 6'h24;
  localparam logic [ADDR_W-1:0] OFF_SET      = 6'h30;

  // Access kinds on the input channel
  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_SAMPLE = 2'd2,
    KIND_IDLE   = 2'd3
  } sei_kind_t;

  // Decoded operations handed to the state engine
  typedef enum logic [3:0] {
    OP_NONE,
    OP_RD_CAUSE_LO,
    OP_RD_CAUSE_HI,
    OP_RD_MASK_LO,
    OP_RD_MASK_HI,
    OP_CLR_CAUSE_LO,
    OP_CLR_CAUSE_HI,
    OP_WR_MASK_LO,
    OP_WR_MASK_HI,
    OP_SET,
    OP_SAMPLE
  } sei_op_code_t;

  // Input beat
  typedef struct packed {
    logic [1:0]         kind;
    logic [ADDR_W-1:0]  address;
    logic [WORD_W-1:0]  write_data;
    logic [WORD_W-1:0]  wired_levels;
  } sei_in_t;

  // Result beat
  typedef struct packed {
    logic [WORD_W-1:0]  read_data;
    logic               irq_out;
    logic [INDEX_W-1:0] first_index;
    logic               first_domain;
    logic [INDEX_W-1:0] first_relative;
    logic               bad_access;
  } sei_out_t;

  // Queue entry: decoded operation, its error flag and its one argument
  typedef struct packed {
    sei_op_code_t       op;
    logic               bad;
    logic [WORD_W-1:0]  arg;
  } sei_op_t;

endpackage

`default_nettype wire

FILE: rtl/sei_front.sv
// ----------------------------------------------------------------------------
// sei_front
// Access decoder: turns a bus access or level sample into one operation for
// the state engine and flags unmapped offsets and out-of-range set numbers.
// ----------------------------------------------------------------------------
`default_nettype none

module sei_front #(
  parameter int SOURCE_COUNT = sei_pkg::SOURCE_COUNT_DEF
) (
  input  wire sei_pkg::sei_in_t  in_data,
  output sei_pkg::sei_op_t       op_item
);
  import sei_pkg::*;

  logic set_in_range;

  // Compare the set number against the number of existing sources
  assign set_in_range = (in_data.write_data < WORD_W'(SOURCE_COUNT));

  // Classify the access
  always_comb begin
    op_item.op  = OP_NONE;
    op_item.bad = 1'b0;
    op_item.arg = in_data.write_data;
    unique case (sei_kind_t'(in_data.kind))
      KIND_READ: begin
        unique case (in_data.address)
          OFF_CAUSE_LO: op_item.op = OP_RD_CAUSE_LO;
          OFF_CAUSE_HI: op_item.op = OP_RD_CAUSE_HI;
          OFF_MASK_LO:  op_item.op = OP_RD_MASK_LO;
          OFF_MASK_HI:  op_item.op = OP_RD_MASK_HI;
          OFF_SET:      op_item.op = OP_NONE;
          default:      op_item.bad = 1'b1;
        endcase
      end
      KIND_WRITE: begin
        unique case (in_data.address)
          OFF_CAUSE_LO: op_item.op = OP_CLR_CAUSE_LO;
          OFF_CAUSE_HI: op_item.op = OP_CLR_CAUSE_HI;
          OFF_MASK_LO:  op_item.op = OP_WR_MASK_LO;
          OFF_MASK_HI:  op_item.op = OP_WR_MASK_HI;
          OFF_SET: begin
            if (set_in_range) begin
              op_item.op = OP_SET;
            end else begin
              op_item.bad = 1'b1;
            end
          end
          default:      op_item.bad = 1'b1;
        endcase
      end
      KIND_SAMPLE: begin
        op_item.op  = OP_SAMPLE;
        op_item.arg = in_data.wired_levels;
      end
      KIND_IDLE: op_item.op = OP_NONE;
      default:   op_item.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/sei_queue.sv
// ----------------------------------------------------------------------------
// sei_queue
// Small register FIFO of decoded operations between the decoder and the
// state engine.
// ----------------------------------------------------------------------------
`default_nettype none

module sei_queue (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    push,
  input  wire sei_pkg::sei_op_t  push_item,
  output logic                   full,
  input  wire                    pop,
  output logic                   not_empty,
  output sei_pkg::sei_op_t       head
);
  import sei_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  sei_op_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full      = (count == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  // Store pushed beats
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue pop while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");

endmodule

`default_nettype wire

FILE: rtl/sei_back.sv
// ----------------------------------------------------------------------------
// sei_back
// State engine: holds cause and mask words, applies one operation per cycle
// unless the output stalls, finds the lowest pending source and registers the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module sei_back #(
  parameter int SOURCE_COUNT = sei_pkg::SOURCE_COUNT_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire [sei_pkg::COUNT_W-1:0]           wired_eff,
  input  wire                                  q_valid,
  input  wire sei_pkg::sei_op_t                q_item,
  output logic                                 q_pop,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output sei_pkg::sei_out_t                    out_data
);
  import sei_pkg::*;

  localparam logic [CAUSE_W-1:0] VALID_MASK = {CAUSE_W{1'b1}} >> (CAUSE_W - SOURCE_COUNT);

  logic [CAUSE_W-1:0] cause;
  logic [CAUSE_W-1:0] mask;
  logic [CAUSE_W-1:0] cause_next;
  logic [CAUSE_W-1:0] mask_next;
  logic [CAUSE_W-1:0] pend;
  logic [WORD_W-1:0]  wired_mask;
  logic [WORD_W-1:0]  rdata;
  logic [INDEX_W-1:0] idx;
  logic               dom;
  logic [INDEX_W-1:0] rel;
  sei_out_t           result;

  // Take a new operation when the output register is free or draining
  assign q_pop = q_valid && (!out_valid || out_ready);

  // Enable the wired sources below the effective count
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      wired_mask[i] = (COUNT_W'(i) < wired_eff);
    end
  end

  // Apply the operation
  always_comb begin
    cause_next = cause;
    mask_next  = mask;
    rdata      = '0;
    unique case (q_item.op)
      OP_NONE:         ;
      OP_RD_CAUSE_LO:  rdata = cause[WORD_W-1:0];
      OP_RD_CAUSE_HI:  rdata = cause[CAUSE_W-1:WORD_W];
      OP_RD_MASK_LO:   rdata = mask[WORD_W-1:0];
      OP_RD_MASK_HI:   rdata = mask[CAUSE_W-1:WORD_W];
      OP_CLR_CAUSE_LO: cause_next = cause & ~{{WORD_W{1'b0}}, q_item.arg};
      OP_CLR_CAUSE_HI: cause_next = cause & ~{q_item.arg, {WORD_W{1'b0}}};
      OP_WR_MASK_LO:   mask_next  = {mask[CAUSE_W-1:WORD_W], q_item.arg};
      OP_WR_MASK_HI:   mask_next  = {q_item.arg, mask[WORD_W-1:0]};
      OP_SET:          cause_next = cause | (CAUSE_W'(1) << q_item.arg[INDEX_W-1:0]);
      OP_SAMPLE:       cause_next = cause | {{WORD_W{1'b0}}, q_item.arg & wired_mask};
      default:         ;
    endcase
    cause_next = cause_next & VALID_MASK;
    mask_next  = mask_next & VALID_MASK;
  end

  // Find the lowest pending unmasked source and its domain
  assign pend = cause_next & ~mask_next;

  always_comb begin
    idx = '0;
    for (int i = CAUSE_W - 1; i >= 0; i--) begin
      if (pend[i]) begin
        idx = INDEX_W'(i);
      end
    end
    dom = (pend != '0) && (idx >= wired_eff);
    rel = dom ? (idx - wired_eff) : idx;
  end

  always_comb begin
    result.read_data      = rdata;
    result.irq_out        = (pend != '0);
    result.first_index    = idx;
    result.first_domain   = dom;
    result.first_relative = rel;
    result.bad_access     = q_item.bad;
  end

  // Hold cause and mask state
  always_ff @(posedge clk) begin
    if (rst) begin
      cause <= '0;
      mask  <= VALID_MASK;
    end else if (q_pop) begin
      cause <= cause_next;
      mask  <= mask_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data <= result;
    end
  end

  a_idle_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.irq_out) |->
      (out_data.first_index == '0 && !out_data.first_domain))
    else $error("source reported with no pending interrupt");

  a_bad_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.bad_access) |-> (out_data.read_data == '0))
    else $error("rejected access returned data");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat changed");

endmodule

`default_nettype wire

FILE: rtl/sei_interrupt_aggregator.sv
// Path: an accepted input beat is registered in the operation queue and then
//   in the output register, where its result beat waits to be taken.
// Throughput: one beat per cycle unless the receiver stalls the output.
// Reset: cause bits clear, mask bits set for every existing source,
//   wired count 21, queue and output register empty.
// ----------------------------------------------------------------------------
// sei_interrupt_aggregator
// Interrupt aggregator top level: access decoder, operation queue, state
// engine and the wired count register.
// ----------------------------------------------------------------------------
`default_nettype none

module sei_interrupt_aggregator #(
  parameter int SOURCE_COUNT = sei_pkg::SOURCE_COUNT_DEF,
  parameter int WIRED_MAX    = sei_pkg::WIRED_MAX_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire sei_pkg::sei_in_t        in_data,
  output logic                         out_valid,
  input  wire                          out_ready,
  output sei_pkg::sei_out_t            out_data,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [sei_pkg::COUNT_W-1:0]   cfg_data
);
  import sei_pkg::*;

  logic [COUNT_W-1:0] wired_count;
  logic [COUNT_W-1:0] wired_eff;
  sei_op_t            dec_item;
  sei_op_t            q_head;
  logic               q_full;
  logic               q_not_empty;
  logic               q_pop;

  // Wired count register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wired_count <= WIRED_COUNT_RST;
    end else if (cfg_valid) begin
      wired_count <= cfg_data;
    end
  end

  // Limit the wired count to the number of wired inputs
  assign wired_eff = (wired_count > COUNT_W'(WIRED_MAX)) ? COUNT_W'(WIRED_MAX) : wired_count;

  assign in_ready = !q_full;

  sei_front #(
    .SOURCE_COUNT (SOURCE_COUNT)
  ) u_front (
    .in_data (in_data),
    .op_item (dec_item)
  );

  sei_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && in_ready),
    .push_item (dec_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  sei_back #(
    .SOURCE_COUNT (SOURCE_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .wired_eff (wired_eff),
    .q_valid   (q_not_empty),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: tb/sv/sei_interrupt_aggregator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sei_interrupt_aggregator_test
// Self-checking bench for the interrupt aggregator. A built-in model tracks
// the cause, mask and wired count. Each access beat is predicted on
// acceptance and every status beat is compared field by field. The run
// covers directed corner accesses, then random phases at several wired
// counts with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module sei_interrupt_aggregator_test;
  import sei_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int SRC_N      = SOURCE_COUNT_DEF;
  localparam int WIRED_LIM  = WIRED_MAX_DEF;
  localparam int PHASE_LEN  = 100;
  localparam bit [63:0] SRC_BITS = (SRC_N >= 64) ? {64{1'b1}} : ((64'd1 << SRC_N) - 64'd1);

  // Model of the aggregator plus the queue of status beats still owed
  class aggregator_scoreboard;
    bit [63:0]      cause_bits;
    bit [63:0]      mask_bits;
    bit [5:0]       wired_count;
    sei_out_t       status_q[$];
    int             fails;
    int             checked;

    function new();
      cause_bits  = '0;
      mask_bits   = SRC_BITS;
      wired_count = WIRED_COUNT_RST;
      fails       = 0;
      checked     = 0;
    endfunction

    // Apply one accepted access and queue the status it must produce
    function void take_access(sei_in_t a);
      sei_out_t  st;
      bit [63:0] pend;
      int        wc;
      int        idx;
      st  = '0;
      idx = 0;
      wc  = int'(wired_count);
      if (wc > WIRED_LIM) wc = WIRED_LIM;
      if (wc > SRC_N) wc = SRC_N;
      case (sei_kind_t'(a.kind))
        KIND_READ: begin
          case (a.address)
            OFF_CAUSE_LO: st.read_data = cause_bits[31:0];
            OFF_CAUSE_HI: st.read_data = cause_bits[63:32];
            OFF_MASK_LO:  st.read_data = mask_bits[31:0];
            OFF_MASK_HI:  st.read_data = mask_bits[63:32];
            OFF_SET:      st.read_data = '0;
            default:      st.bad_access = 1'b1;
          endcase
        end
        KIND_WRITE: begin
          case (a.address)
            OFF_CAUSE_LO: cause_bits = cause_bits & ~{32'h0, a.write_data};
            OFF_CAUSE_HI: cause_bits = cause_bits & ~{a.write_data, 32'h0};
            OFF_MASK_LO:  mask_bits = {mask_bits[63:32], a.write_data} & SRC_BITS;
            OFF_MASK_HI:  mask_bits = {a.write_data, mask_bits[31:0]} & SRC_BITS;
            OFF_SET: begin
              if (a.write_data < SRC_N) cause_bits[a.write_data[5:0]] = 1'b1;
              else st.bad_access = 1'b1;
            end
            default:      st.bad_access = 1'b1;
          endcase
        end
        KIND_SAMPLE: cause_bits = cause_bits | ({32'h0, a.wired_levels} & ((64'd1 << wc) - 64'd1));
        default: ;
      endcase
      cause_bits = cause_bits & SRC_BITS;

      // Lowest pending unmasked source, split into domain and offset
      pend = cause_bits & ~mask_bits & SRC_BITS;
      for (int i = 63; i >= 0; i--) if (pend[i]) idx = i;
      if (pend != 0) begin
        st.irq_out     = 1'b1;
        st.first_index = idx[5:0];
        if (idx >= wc) begin
          st.first_domain   = 1'b1;
          st.first_relative = 6'(idx - wc);
        end else begin
          st.first_relative = idx[5:0];
        end
      end
      status_q.push_back(st);
    endfunction

    function void note_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        fails++;
        if (fails <= 10)
          $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
    endfunction

    // Compare one status beat against the oldest prediction
    function void check_status(sei_out_t got);
      sei_out_t want;
      if (status_q.size() == 0) begin
        fails++;
        if (fails <= 10) $display("%0t ns: unexpected status beat 0x%0h", $time, got);
        return;
      end
      want = status_q.pop_front();
      checked++;
      note_field("read_data", want.read_data, got.read_data);
      note_field("irq_out", 32'(want.irq_out), 32'(got.irq_out));
      note_field("first_index", 32'(want.first_index), 32'(got.first_index));
      note_field("first_domain", 32'(want.first_domain), 32'(got.first_domain));
      note_field("first_relative", 32'(want.first_relative), 32'(got.first_relative));
      note_field("bad_access", 32'(want.bad_access), 32'(got.bad_access));
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  sei_in_t               in_data;
  logic                  out_valid;
  logic                  out_ready;
  sei_out_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [COUNT_W-1:0]    cfg_data;

  aggregator_scoreboard  sb;
  int                    idle_pct;
  int                    stall_pct;
  int                    accesses;
  int                    cfg_writes;

  sei_interrupt_aggregator i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Free-running clock
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Random receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Predict on every accepted access beat, check every accepted status beat
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        sb.take_access(in_data);
        accesses++;
      end
      if (out_valid && out_ready) sb.check_status(out_data);
    end
  end

  // Hard stop for a hung run
  initial begin
    #(CLK_PERIOD * 400000);
    $display("sei_interrupt_aggregator verification failed");
    $finish;
  end

  function automatic sei_in_t make_access(sei_kind_t k, logic [5:0] adr, logic [31:0] wd,
                                          logic [31:0] lv);
    sei_in_t a;
    a.kind         = k;
    a.address      = adr;
    a.write_data   = wd;
    a.wired_levels = lv;
    return a;
  endfunction

  // Word with a random flavor: dense, single bit, all ones, zero, sparse, one hole
  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'h1 << $urandom_range(31);
      2: return '1;
      3: return '0;
      4: return $urandom & $urandom & $urandom;
      default: return ~(32'h1 << $urandom_range(31));
    endcase
  endfunction

  function automatic logic [5:0] pick_mapped();
    case ($urandom_range(4))
      0: return OFF_CAUSE_LO;
      1: return OFF_CAUSE_HI;
      2: return OFF_MASK_LO;
      3: return OFF_MASK_HI;
      default: return OFF_SET;
    endcase
  endfunction

  // Mostly well-formed register traffic, with some noise
  function automatic sei_in_t random_access();
    int          r;
    logic [31:0] num;
    r = $urandom_range(99);
    if (r < 20) return make_access(KIND_READ, pick_mapped(), $urandom, $urandom);
    if (r < 33)
      return make_access(KIND_WRITE, ($urandom_range(1) != 0) ? OFF_CAUSE_HI : OFF_CAUSE_LO,
                         pick_word(), $urandom);
    if (r < 48)
      return make_access(KIND_WRITE, ($urandom_range(1) != 0) ? OFF_MASK_HI : OFF_MASK_LO,
                         pick_word(), $urandom);
    if (r < 68) begin
      case ($urandom_range(19))
        0:       num = $urandom;
        1, 2:    num = $urandom_range(127, 64);
        default: num = $urandom_range(63);
      endcase
      return make_access(KIND_WRITE, OFF_SET, num, $urandom);
    end
    if (r < 88) return make_access(KIND_SAMPLE, 6'($urandom_range(63)), $urandom, pick_word());
    if (r < 95)
      return make_access(($urandom_range(1) != 0) ? KIND_WRITE : KIND_READ,
                         6'($urandom_range(63)), $urandom, $urandom);
    return make_access(KIND_IDLE, 6'($urandom_range(63)), $urandom, $urandom);
  endfunction

  // Present one access beat and hold it until accepted
  task automatic send_access(sei_in_t a);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold off until every owed status beat has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.status_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_wired_count(logic [COUNT_W-1:0] value);
    drain();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.wired_count = value;
    cfg_writes++;
    repeat (2) @(posedge clk);
  endtask

  initial begin
    int phase_wc[6];
    int phase_idle[6];
    int phase_stall[6];
    sb          = new();
    clk         = 1'b0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    accesses    = 0;
    cfg_writes  = 0;
    phase_wc    = '{0, 32, 63, 1, 0, 21};
    phase_idle  = '{0, 68, 0, 27, 68, 0};
    phase_stall = '{0, 0, 68, 27, 0, 68};
    phase_wc[4] = $urandom_range(63);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed corners at the reset wired count
    write_wired_count(WIRED_COUNT_RST);
    send_access(make_access(KIND_READ, OFF_CAUSE_LO, '0, '0));
    send_access(make_access(KIND_READ, OFF_MASK_LO, '0, '0));
    send_access(make_access(KIND_READ, OFF_MASK_HI, '1, '1));
    send_access(make_access(KIND_READ, OFF_SET, '1, '0));
    send_access(make_access(KIND_READ, 6'h3f, '0, '0));
    send_access(make_access(KIND_WRITE, OFF_MASK_LO, '0, '1));
    send_access(make_access(KIND_WRITE, OFF_MASK_HI, '0, '0));
    send_access(make_access(KIND_SAMPLE, 6'h3f, '0, '1));
    send_access(make_access(KIND_WRITE, OFF_SET, 32'd63, '0));
    send_access(make_access(KIND_WRITE, OFF_SET, 32'd64, '0));
    send_access(make_access(KIND_WRITE, OFF_SET, '1, '0));
    send_access(make_access(KIND_WRITE, OFF_SET, 32'd5, '0));
    send_access(make_access(KIND_READ, OFF_CAUSE_LO, '0, '0));
    send_access(make_access(KIND_READ, OFF_CAUSE_HI, '0, '0));
    send_access(make_access(KIND_WRITE, OFF_CAUSE_LO, '1, '0));
    send_access(make_access(KIND_READ, OFF_CAUSE_LO, '0, '0));
    send_access(make_access(KIND_WRITE, OFF_SET, 32'd21, '0));
    send_access(make_access(KIND_WRITE, OFF_SET, 32'd20, '0));
    send_access(make_access(KIND_IDLE, 6'h3f, '1, '1));
    send_access(make_access(KIND_WRITE, 6'h10, '1, '0));
    send_access(make_access(KIND_SAMPLE, '0, '0, 32'h8000_0000));
    send_access(make_access(KIND_WRITE, OFF_CAUSE_HI, '1, '0));
    send_access(make_access(KIND_WRITE, OFF_CAUSE_LO, '1, '0));
    send_access(make_access(KIND_WRITE, OFF_MASK_HI, '1, '0));
    send_access(make_access(KIND_READ, OFF_MASK_HI, '0, '0));

    // Random phases, each at its own wired count and traffic shape
    for (int p = 0; p < 6; p++) begin
      write_wired_count(COUNT_W'(phase_wc[p]));
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (p == 3 && n == PHASE_LEN / 2) drain();
        send_access(random_access());
      end
    end

    // Let the tail drain, then settle
    drain();
    stall_pct = 0;
    repeat (8) @(posedge clk);

    $display("Ran %0d accesses through %0d wired-count writes (0, 1, 21, 32, 63, %0d).",
             accesses, cfg_writes, phase_wc[4]);
    $display("Checked %0d status beats, %0d field mismatches.", sb.checked, sb.fails);
    if (sb.fails == 0 && sb.status_q.size() == 0) begin
      $display("sei_interrupt_aggregator verification clean");
    end else begin
      $display("sei_interrupt_aggregator verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/sei_pkg.sv
rtl/sei_front.sv
rtl/sei_queue.sv
rtl/sei_back.sv
rtl/sei_interrupt_aggregator.sv
tb/sv/sei_interrupt_aggregator_test.sv
